### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

### hw/rtl/rc_pkg.sv
// Radix converter package: payload types, constants and digit helpers.
`default_nettype none

package rc_pkg;

  localparam int unsigned CHAR_BITS       = 8;
  localparam int unsigned RADIX_BITS      = 6;
  localparam int unsigned STORE_DEPTH     = 64;
  localparam int unsigned STORE_ADDR_BITS = 6;
  localparam int unsigned DCOUNT_BITS     = 7;
  localparam int unsigned CFG_INDEX_BITS  = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_BASE = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_BASE = 1'b1;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN    = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX    = 6'd36;
  localparam logic [RADIX_BITS-1:0] SOURCE_RESET = 6'd10;
  localparam logic [RADIX_BITS-1:0] TARGET_RESET = 6'd2;
  localparam logic [RADIX_BITS-1:0] NOT_A_DIGIT  = 6'd36;
  localparam logic [RADIX_BITS-1:0] DECIMAL_TOP  = 6'd9;
  localparam logic [RADIX_BITS-1:0] LETTER_BASE  = 6'd10;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z = 8'h7A;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 is_last;
  } char_req_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] out_char;
    logic                 is_last_out;
    logic                 error;
  } digit_req_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_RD   = 5'b00100,
    S_WAIT = 5'b01000,
    S_OUT  = 5'b10000
  } rc_state_t;

  function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
    logic [RADIX_BITS-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  // 0..35 for a digit character, NOT_A_DIGIT otherwise.
  function automatic logic [RADIX_BITS-1:0] char_value(input logic [CHAR_BITS-1:0] c);
    logic [RADIX_BITS-1:0] res;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      res = RADIX_BITS'(c - CHAR_ZERO);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      res = RADIX_BITS'(c - CHAR_LOWER_A) + LETTER_BASE;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      res = RADIX_BITS'(c - CHAR_UPPER_A) + LETTER_BASE;
    end else begin
      res = NOT_A_DIGIT;
    end
    return res;
  endfunction

  function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [RADIX_BITS-1:0] dv);
    logic [CHAR_BITS-1:0] res;
    if (dv > DECIMAL_TOP) begin
      res = CHAR_BITS'(dv - LETTER_BASE) + CHAR_UPPER_A;
    end else begin
      res = CHAR_BITS'(dv) + CHAR_ZERO;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/radix_converter.sv
// Radix converter top level: digit accumulator, bit-serial divider and digit emitter.
// Usage:
//   Character channel (char_valid / char_stall / char_req): one ASCII digit per
//   request, most significant first, is_last on the final one. Digits 0-9, a-z,
//   A-Z are accepted. Each non-last character is one multiply-add by the source
//   radix into the accumulator; characters stream at one per cycle while idle.
//   On the last character the block stalls the character channel and converts:
//   a restoring divider takes one quotient bit per cycle, over all VALUE_BITS
//   quotient bits for every target digit.
//   Digit channel (digit_valid / digit_stall / digit_req): target digits, most
//   significant first, upper-case letters, is_last_out on the final one. After the
//   divider, the digit store is read (S_RD, S_WAIT) into the output register shown
//   in S_OUT; each next digit passes S_WAIT again once the receiver takes the one
//   before. A stall simply holds the output register and the sequencer.
//   An invalid digit or accumulator overflow gives one request with error set,
//   in the cycle after the last character.
//   Configuration (cfg_we / cfg_index / cfg_data) is to be written by the user
//   between numbers; the block itself does not enforce it.
//   Reset (rst, synchronous): source radix 10, target radix 2, run cleared, idle.
`default_nettype none
`include "assert_macros.svh"

module radix_converter
  import rc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [RADIX_BITS-1:0]     cfg_data,
  input  logic                      char_valid,
  output logic                      char_stall,
  input  char_req_t                 char_req,
  output logic                      digit_valid,
  input  logic                      digit_stall,
  output digit_req_t                digit_req
);

  localparam int unsigned BIT_CNT_BITS = $clog2(VALUE_BITS);
  localparam int unsigned PROD_BITS    = VALUE_BITS + RADIX_BITS;
  localparam int unsigned SUM_BITS     = PROD_BITS + 1;
  localparam logic [BIT_CNT_BITS-1:0] LAST_BIT = BIT_CNT_BITS'(VALUE_BITS - 1);

  // config
  logic [RADIX_BITS-1:0] source_base;
  logic [RADIX_BITS-1:0] target_base;

  // run state
  rc_state_t             state;
  logic [VALUE_BITS-1:0] accumulator;
  logic                  error_seen;
  logic [DCOUNT_BITS-1:0] digit_count;

  // divider
  logic [VALUE_BITS-1:0]   quot;
  logic [RADIX_BITS-1:0]   rem;
  logic [BIT_CNT_BITS-1:0] bit_cnt;

  digit_req_t out_q;

  logic [RADIX_BITS-1:0] sb;
  logic [RADIX_BITS-1:0] tb;
  logic [RADIX_BITS-1:0] dval;
  logic [PROD_BITS-1:0]  prod;
  logic [SUM_BITS-1:0]   sum;
  logic                  bad_digit;
  logic                  ovf;
  logic                  err_step;
  logic [VALUE_BITS-1:0] acc_step;

  logic [RADIX_BITS:0]    rs;
  logic                   ge;
  logic [RADIX_BITS-1:0]  rem_step;
  logic [VALUE_BITS-1:0]  quot_step;
  logic [DCOUNT_BITS-1:0] count_inc;
  logic [DCOUNT_BITS-1:0] count_dec;
  logic                   more;
  logic                   digit_done;

  logic                  ram_we;
  logic [RADIX_BITS-1:0] ram_rdata;

  assign sb   = clamp_radix(source_base);
  assign tb   = clamp_radix(target_base);
  assign dval = char_value(char_req.digit_char);

  // Multiply-add; any bit above VALUE_BITS means overflow.
  assign prod      = {{RADIX_BITS{1'b0}}, accumulator} * {{VALUE_BITS{1'b0}}, sb};
  assign sum       = {1'b0, prod} + SUM_BITS'(dval);
  assign bad_digit = dval >= sb;
  assign ovf       = |sum[SUM_BITS-1:VALUE_BITS];
  assign err_step  = error_seen | bad_digit | ovf;
  assign acc_step  = err_step ? accumulator : sum[VALUE_BITS-1:0];

  // One restoring division step; the quotient shifts in where the dividend leaves.
  assign rs        = {rem, quot[VALUE_BITS-1]};
  assign ge        = rs >= {1'b0, tb};
  assign rem_step  = ge ? RADIX_BITS'(rs - {1'b0, tb}) : rs[RADIX_BITS-1:0];
  assign quot_step = {quot[VALUE_BITS-2:0], ge};

  assign count_inc  = digit_count + DCOUNT_BITS'(1);
  assign count_dec  = digit_count - DCOUNT_BITS'(1);
  assign digit_done = (state == S_DIV) && (bit_cnt == LAST_BIT);
  assign more       = (quot_step != '0) && (count_inc < DCOUNT_BITS'(STORE_DEPTH));
  assign ram_we     = digit_done;

  assign char_stall  = (state != S_IDLE);
  assign digit_valid = (state == S_OUT);
  assign digit_req   = out_q;

  // Digit store: least significant digit at entry 0; read address tracks count - 1.
  rc_ram #(
    .WIDTH(RADIX_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(digit_count[STORE_ADDR_BITS-1:0]),
    .wdata(rem_step),
    .raddr(count_dec[STORE_ADDR_BITS-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      source_base <= SOURCE_RESET;
      target_base <= TARGET_RESET;
      state       <= S_IDLE;
      accumulator <= '0;
      error_seen  <= 1'b0;
      digit_count <= '0;
      bit_cnt     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SOURCE_BASE: source_base <= cfg_data;
          REG_TARGET_BASE: target_base <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (char_valid) begin
            if (char_req.is_last) begin
              // run ends here: clear and hand off to divider or error result
              accumulator <= '0;
              error_seen  <= 1'b0;
              digit_count <= '0;
              if (err_step) begin
                out_q <= '{out_char: '0, is_last_out: 1'b1, error: 1'b1};
                state <= S_OUT;
              end else begin
                quot    <= acc_step;
                rem     <= '0;
                bit_cnt <= '0;
                state   <= S_DIV;
              end
            end else begin
              accumulator <= acc_step;
              error_seen  <= err_step;
            end
          end
        end
        S_DIV: begin
          quot <= quot_step;
          if (digit_done) begin
            // remainder goes to the store this cycle; restart on the quotient
            rem         <= '0;
            bit_cnt     <= '0;
            digit_count <= count_inc;
            if (!more) begin
              state <= S_RD;
            end
          end else begin
            rem     <= rem_step;
            bit_cnt <= bit_cnt + BIT_CNT_BITS'(1);
          end
        end
        S_RD: begin
          digit_count <= count_dec;
          state       <= S_WAIT;
        end
        S_WAIT: begin
          out_q <= '{out_char:    digit_to_ascii(ram_rdata),
                     is_last_out: (digit_count == '0),
                     error:       1'b0};
          state <= S_OUT;
        end
        S_OUT: begin
          if (!digit_stall) begin
            if (digit_count == '0) begin
              state <= S_IDLE;
            end else begin
              digit_count <= count_dec;
              state       <= S_WAIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Divider remainder always stays below the target radix.
  `ASSERT_IMPL(a_rem_bound, state == S_DIV, rem < tb)
  // Digit count never exceeds the store depth.
  `ASSERT_IMPL(a_count_range, 1'b1, digit_count <= DCOUNT_BITS'(STORE_DEPTH))
  // A delivered final request returns the block to idle.
  `ASSERT_NEXT(a_last_ends, digit_valid && !digit_stall && digit_req.is_last_out,
               state == S_IDLE)

endmodule

`default_nettype wire

### hw/rtl/rc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rc_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
